// ===== src/sspc_pkg.sv =====
package sspc_pkg;

    localparam int STATE_COUNT_DEF = 5;
    localparam int DUTY_BITS_DEF   = 8;

    localparam int FRAC_W  = 16;
    localparam int COEF_W  = 26;
    localparam int STATE_W = 40;
    localparam int ACC_W   = 54;
    localparam int ERR_W   = 21;
    localparam int ROM_DIM = 8;
    localparam int ROM_IW  = 3;

    localparam logic signed [ERR_W-1:0] ERR_LIMIT = 21'sd655360;

    typedef logic signed [COEF_W-1:0] coef_t;

    // Sequencer strobes shared by every cell and the output accumulator
    typedef struct packed {
        logic clear;
        logic mul_lo;
        logic mul_hi;
        logic use_err;
        logic shift;
        logic commit;
    } sspc_ctl_t;

    localparam coef_t A_ROM [ROM_DIM][ROM_DIM] = '{
        '{26'sd65536, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0},
        '{26'sd224775, 26'sd10918, -26'sd127350, -26'sd505997, -26'sd2167066,
          26'sd0, 26'sd0, 26'sd0},
        '{26'sd11239, 26'sd3821, 26'sd59166, -26'sd25297, -26'sd108351,
          26'sd0, 26'sd0, 26'sd0},
        '{26'sd138, 26'sd46, 26'sd1560, 26'sd65221, -26'sd1357,
          26'sd0, 26'sd0, 26'sd0},
        '{26'sd0, 26'sd0, 26'sd7, 26'sd819, 26'sd65523, 26'sd0, 26'sd0, 26'sd0},
        '{26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0},
        '{26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0},
        '{26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0}
    };

    localparam coef_t B_ROM [ROM_DIM] = '{
        26'sd819, 26'sd1402, 26'sd72, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0
    };

    localparam coef_t C_ROM [ROM_DIM] = '{
        26'sd2526295, -26'sd451412, -26'sd1305575, -26'sd5672206, -26'sd24356343,
        26'sd0, 26'sd0, 26'sd0
    };

    localparam coef_t D_COEF = 26'sd15788;

    function automatic coef_t a_coef(input logic [ROM_IW-1:0] i, input logic [ROM_IW-1:0] j);
        return A_ROM[i][j];
    endfunction

    function automatic coef_t b_coef(input logic [ROM_IW-1:0] i);
        return B_ROM[i];
    endfunction

    function automatic coef_t c_coef(input logic [ROM_IW-1:0] i);
        return C_ROM[i];
    endfunction

    function automatic logic signed [STATE_W-1:0] sat40(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'({1'b0, {(STATE_W-1){1'b1}}});
        lo = -hi - ACC_W'(1);
        if (v > hi)
            return STATE_W'(hi);
        else if (v < lo)
            return STATE_W'(lo);
        return STATE_W'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(33'sh0_7FFF_FFFF);
        lo = -hi - ACC_W'(1);
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

// ===== src/state_space_position_controller.sv =====
// Five-state position controller, one result beat per distance beat. Each item
// is processed by the row of state cells: each cell owns one state entry and one
// multiply-accumulate, the entries rotate one place along the ring per step, and
// every step forms a split 26x40 product, low half first, then the high half.
// One item is in flight at a time; a finished result waits in the output
// register while the next item is taken. Configuration writes take effect at
// once and belong in idle periods.
module state_space_position_controller #(
    parameter int STATE_COUNT = sspc_pkg::STATE_COUNT_DEF,
    parameter int DUTY_BITS   = sspc_pkg::DUTY_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [12:0]                   distance_mm,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [DUTY_BITS-1:0]          pwm_duty,
    output logic [20:0]                   drive_volts,
    output logic signed [20:0]            clamped_error,
    output logic signed [26:0]            measured_position,
    input  logic                          wr_en,
    input  logic [2:0]                    wr_index,
    input  logic [23:0]                   wr_data
);
    import sspc_pkg::*;

    localparam int KW = $clog2(STATE_COUNT + 1);
    localparam int NW = DUTY_BITS + 2;
    localparam logic [KW-1:0]        K_LAST = KW'(STATE_COUNT);
    localparam logic [DUTY_BITS-1:0] DMAX   = '1;
    localparam logic [28:0]          RECIP5 = 29'd429496730;
    localparam logic [19:0]          RECIP3 = 20'd699051;

    localparam logic [2:0] REG_REF  = 3'd0;
    localparam logic [2:0] REG_CAL  = 3'd1;
    localparam logic [2:0] REG_OP   = 3'd2;
    localparam logic [2:0] REG_MIN  = 3'd3;
    localparam logic [2:0] REG_MAX  = 3'd4;
    localparam logic [2:0] REG_DZ   = 3'd5;
    localparam logic [2:0] REG_GAIN = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_POS, S_ERR, S_LO, S_HI, S_GAIN, S_MUL, S_CMD, S_LIM, S_DUTY1, S_DUTY2
    } state_t;

    state_t state_reg;

    logic signed [23:0] ref_reg;
    logic [22:0]        cal_reg;
    logic [20:0]        op_reg;
    logic [20:0]        min_reg;
    logic [20:0]        max_reg;
    logic [20:0]        dz_reg;
    logic [18:0]        gain_reg;

    logic [KW-1:0]             k_reg;
    logic [12:0]               dist_reg;
    logic signed [26:0]        pos_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [31:0]        lin_reg;
    logic signed [51:0]        prod_reg;
    logic signed [31:0]        cmd_reg;
    logic [20:0]               volts_reg;
    logic [NW-1:0]             n_reg;
    logic                      out_valid_reg;
    logic [DUTY_BITS-1:0]      duty_reg;
    logic [20:0]               volts_out_reg;
    logic signed [ERR_W-1:0]   err_out_reg;
    logic signed [26:0]        pos_out_reg;

    sspc_ctl_t                 ctl;
    logic signed [STATE_W-1:0] x_bus [STATE_COUNT];
    logic signed [ACC_W-1:0]   out_acc;
    coef_t                     out_coef;
    logic signed [STATE_W-1:0] out_operand;

    logic [41:0]               pos_q;
    logic signed [26:0]        pos_next;
    logic signed [27:0]        err_wide;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [51:0]        prod_next;
    logic signed [31:0]        gain_sat;
    logic signed [31:0]        cmd_next;
    logic signed [31:0]        dz_sum;
    logic [20:0]               volts_next;
    logic [21+DUTY_BITS-1:0]   vprod;
    logic [NW+19:0]            qprod;
    logic [NW-2:0]             q;
    logic [DUTY_BITS-1:0]      duty_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg  <= -24'sd1507328;
            cal_reg  <= 23'd1376256;
            op_reg   <= 21'd1048576;
            min_reg  <= 21'd327680;
            max_reg  <= 21'd1572864;
            dz_reg   <= 21'd0;
            gain_reg <= 19'd26214;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_REF:  ref_reg  <= wr_data;
                REG_CAL:  cal_reg  <= wr_data[22:0];
                REG_OP:   op_reg   <= wr_data[20:0];
                REG_MIN:  min_reg  <= wr_data[20:0];
                REG_MAX:  max_reg  <= wr_data[20:0];
                REG_DZ:   dz_reg   <= wr_data[20:0];
                REG_GAIN: gain_reg <= wr_data[18:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        ctl.clear   = (state_reg == S_ERR);
        ctl.mul_lo  = (state_reg == S_LO);
        ctl.mul_hi  = (state_reg == S_HI);
        ctl.use_err = (k_reg == K_LAST);
        ctl.shift   = (state_reg == S_HI) && (k_reg != K_LAST);
        ctl.commit  = (state_reg == S_GAIN);
    end

    genvar gi;
    generate
        for (gi = 0; gi < STATE_COUNT; gi++)
        begin : g_cell
            sspc_cell #(
                .ROW         (gi),
                .STATE_COUNT (STATE_COUNT),
                .KW          (KW)
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .k     (k_reg),
                .err   (err_reg),
                .x_in  (x_bus[(gi + 1) % STATE_COUNT]),
                .x_out (x_bus[gi])
            );
        end
    endgenerate

    // Output row taps the head of the ring, which carries entry k at step k
    assign out_coef    = (k_reg == K_LAST) ? D_COEF : c_coef(ROM_IW'(k_reg));
    assign out_operand = ctl.use_err ? STATE_W'(err_reg) : x_bus[0];

    sspc_mac u_out_mac (
        .clk     (clk),
        .ctl     (ctl),
        .coef    (out_coef),
        .operand (out_operand),
        .acc     (out_acc)
    );

    // distance/10 in Q16.16 as a reciprocal multiply by 2^31/5
    assign pos_q    = dist_reg * RECIP5;
    assign pos_next = $signed({4'b0, cal_reg}) - $signed({1'b0, pos_q[41:16]});
    assign err_wide = 28'(ref_reg) - 28'(pos_reg);

    always_comb
    begin
        if (err_wide > 28'(ERR_LIMIT))
            err_next = ERR_LIMIT;
        else if (err_wide < -28'(ERR_LIMIT))
            err_next = -ERR_LIMIT;
        else
            err_next = err_wide[ERR_W-1:0];
    end

    assign prod_next = lin_reg * $signed({1'b0, gain_reg});
    assign gain_sat  = sat32(ACC_W'(prod_reg >>> FRAC_W));
    assign cmd_next  = sat32(ACC_W'(gain_sat) + ACC_W'($signed({1'b0, op_reg})));
    assign dz_sum    = (cmd_reg != 32'sd0)
                       ? sat32(ACC_W'(cmd_reg) + ACC_W'($signed({1'b0, dz_reg})))
                       : cmd_reg;

    always_comb
    begin
        if (dz_sum < $signed({11'b0, min_reg}))
            volts_next = min_reg;
        else if (dz_sum > $signed({11'b0, max_reg}))
            volts_next = max_reg;
        else
            volts_next = dz_sum[20:0];
    end

    // volts*DMAX / (3*2^19): shift out the power of two, then divide by three
    assign vprod = volts_reg * DMAX;
    assign qprod = n_reg * RECIP3;
    assign q     = qprod[NW+19:21];
    assign duty_next = (q > (NW-1)'(DMAX)) ? DMAX : q[DUTY_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            dist_reg      <= '0;
            pos_reg       <= '0;
            err_reg       <= '0;
            lin_reg       <= '0;
            prod_reg      <= '0;
            cmd_reg       <= '0;
            volts_reg     <= '0;
            n_reg         <= '0;
            duty_reg      <= '0;
            volts_out_reg <= '0;
            err_out_reg   <= '0;
            pos_out_reg   <= '0;
        end
        else
        begin
            // drop the beat once taken, unless the duty stage reloads it
            if (out_valid_reg && out_ready && (state_reg != S_DUTY2))
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        dist_reg  <= distance_mm;
                        state_reg <= S_POS;
                    end
                end
                S_POS:
                begin
                    pos_reg   <= pos_next;
                    state_reg <= S_ERR;
                end
                S_ERR:
                begin
                    err_reg   <= err_next;
                    k_reg     <= '0;
                    state_reg <= S_LO;
                end
                S_LO:
                    state_reg <= S_HI;
                S_HI:
                begin
                    if (k_reg == K_LAST)
                        state_reg <= S_GAIN;
                    else
                    begin
                        k_reg     <= k_reg + KW'(1);
                        state_reg <= S_LO;
                    end
                end
                S_GAIN:
                begin
                    lin_reg   <= sat32(out_acc);
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_CMD;
                end
                S_CMD:
                begin
                    cmd_reg   <= cmd_next;
                    state_reg <= S_LIM;
                end
                S_LIM:
                begin
                    volts_reg <= volts_next;
                    state_reg <= S_DUTY1;
                end
                S_DUTY1:
                begin
                    n_reg     <= vprod[21+DUTY_BITS-1:19];
                    state_reg <= S_DUTY2;
                end
                S_DUTY2:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        duty_reg      <= duty_next;
                        volts_out_reg <= volts_reg;
                        err_out_reg   <= err_reg;
                        pos_out_reg   <= pos_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign pwm_duty          = duty_reg;
    assign drive_volts       = volts_out_reg;
    assign clamped_error     = err_out_reg;
    assign measured_position = pos_out_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat taken while one is in flight");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DUTY2))
        else $error("result raised outside the duty stage");

    a_error_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (clamped_error <= ERR_LIMIT) && (clamped_error >= -ERR_LIMIT))
        else $error("error beyond clamp");

    a_drive_limits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (min_reg <= max_reg) |->
            (drive_volts >= min_reg) && (drive_volts <= max_reg))
        else $error("drive outside limits");

endmodule

// ===== src/sspc_mac.sv =====
module sspc_mac (
    input  logic                                   clk,
    input  sspc_pkg::sspc_ctl_t                    ctl,
    input  logic signed [sspc_pkg::COEF_W-1:0]     coef,
    input  logic signed [sspc_pkg::STATE_W-1:0]    operand,
    output logic signed [sspc_pkg::ACC_W-1:0]      acc
);
    import sspc_pkg::*;

    logic signed [COEF_W+FRAC_W:0]        lo_prod;
    logic signed [COEF_W+STATE_W-FRAC_W-1:0] hi_prod;
    logic signed [COEF_W:0]               frac_reg;
    logic signed [ACC_W-1:0]              acc_reg;
    logic signed [ACC_W-1:0]              acc_next;

    // Floored product in two halves: low operand bits first, then the high part
    assign lo_prod  = coef * $signed({1'b0, operand[FRAC_W-1:0]});
    assign hi_prod  = coef * $signed(operand[STATE_W-1:FRAC_W]);
    assign acc_next = acc_reg + ACC_W'(hi_prod) + ACC_W'(frac_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.mul_lo)
        begin
            frac_reg <= lo_prod[COEF_W+FRAC_W:FRAC_W];
        end
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctl.mul_hi)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== src/sspc_cell.sv =====
module sspc_cell #(
    parameter int ROW         = 0,
    parameter int STATE_COUNT = sspc_pkg::STATE_COUNT_DEF,
    parameter int KW          = $clog2(STATE_COUNT + 1)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sspc_pkg::sspc_ctl_t                   ctl,
    input  logic [KW-1:0]                         k,
    input  logic signed [sspc_pkg::ERR_W-1:0]     err,
    input  logic signed [sspc_pkg::STATE_W-1:0]   x_in,
    output logic signed [sspc_pkg::STATE_W-1:0]   x_out
);
    import sspc_pkg::*;

    localparam logic [KW-1:0] K_LAST = KW'(STATE_COUNT);

    logic signed [STATE_W-1:0] x_reg;
    logic signed [STATE_W-1:0] x_next;
    logic signed [STATE_W-1:0] operand;
    logic signed [ACC_W-1:0]   acc;
    coef_t                     coef;

    // The ring has rotated k places, so this cell now holds state entry ROW+k modulo STATE_COUNT
    always_comb
    begin
        int j;
        j = ROW + int'(k);
        if (j >= STATE_COUNT)
            j = j - STATE_COUNT;
        if (k == K_LAST)
            coef = b_coef(ROM_IW'(ROW));
        else
            coef = a_coef(ROM_IW'(ROW), ROM_IW'(j));
    end

    assign operand = ctl.use_err ? STATE_W'(err) : x_reg;

    sspc_mac u_mac (
        .clk     (clk),
        .ctl     (ctl),
        .coef    (coef),
        .operand (operand),
        .acc     (acc)
    );

    always_comb
    begin
        x_next = x_reg;
        if (ctl.commit)
            x_next = sat40(acc);
        else if (ctl.shift)
            x_next = x_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            x_reg <= '0;
        else
            x_reg <= x_next;
    end

    assign x_out = x_reg;

endmodule
